[hdl/kdef_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and code tables for the key debounce event FIFO.
// Depends on nothing; every other file of the block but kdef_ram imports it.
package kdef_pkg;

  localparam int unsigned NUM_KEYS  = 6;
  localparam int unsigned NSLOT     = 2 * NUM_KEYS;
  localparam int unsigned SLOT_IW   = $clog2(NSLOT);
  localparam int unsigned CODE_W    = 5;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned FT_W      = 4;
  localparam int unsigned LT_W      = 16;
  localparam int unsigned CFG_AW    = 2;
  localparam int unsigned CFG_DW    = 16;
  localparam int unsigned FT_RESET  = 5;
  localparam int unsigned LT_RESET  = 100;
  localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(FT_RESET / 2);
  localparam logic [CODE_W-1:0] CODE_MAX = CODE_W'(3 * NUM_KEYS);

  localparam logic [1:0] ACT_SCAN  = 2'd0;
  localparam logic [1:0] ACT_POP   = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_PRESSED = 2'd1;
  localparam logic [1:0] MODE_LONG    = 2'd3;

  localparam logic [CFG_AW-1:0] CFG_FILTER    = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_LONG_FIRST = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_LONG_REST  = 2'd2;

  localparam int unsigned OFS_PRESS   = 1;
  localparam int unsigned OFS_RELEASE = 2;
  localparam int unsigned OFS_LONG    = 3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_POP,
    ST_DONE
  } kdef_state_t;

  typedef struct packed {
    logic [1:0] action;
    logic       wkup_pressed;
    logic       key0_pressed;
    logic       key1_pressed;
    logic       key2_pressed;
  } kdef_in_t;

  typedef struct packed {
    logic [CODE_W-1:0]       key_code;
    logic                    fifo_empty;
    logic [2*NUM_KEYS-1:0]   key_states;
  } kdef_out_t;

  typedef struct packed {
    logic              v;
    logic [CODE_W-1:0] code;
  } kdef_evt_t;

  function automatic logic [3:0] key_pattern(input int unsigned idx);
    logic [3:0] p;
    case (idx)
      0: p = 4'h1;
      1: p = 4'h2;
      2: p = 4'h4;
      3: p = 4'h8;
      4: p = 4'h3;
      5: p = 4'h6;
      default: p = 4'h0;
    endcase
    return p;
  endfunction

  function automatic logic [CODE_W-1:0] key_code(input int unsigned idx,
                                                 input int unsigned ofs);
    return CODE_W'(3 * idx + ofs);
  endfunction

endpackage

[hdl/kdef_ram.sv]
`timescale 1ns / 1ps
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module kdef_ram #(
  parameter int unsigned WIDTH = 5,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/kdef_lane.sv]
`timescale 1ns / 1ps
// One key lane: debounce counter, long-press counter and key mode.
// Depends on kdef_pkg for the pin pattern and event code tables.
module kdef_lane
  import kdef_pkg::*;
#(
  parameter int unsigned KEY_IDX = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              scan,
  input  logic [3:0]        pins,
  input  logic [FT_W-1:0]   filter_time,
  input  logic [LT_W-1:0]   long_time,
  output logic [1:0]        mode,
  output kdef_evt_t [1:0]   ev
);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       mode_r, mode_nxt;
  logic [LT_W-1:0]  lc_r, lc_nxt;
  logic             down;
  logic [CNT_W-1:0] ft1, ft2;

  assign down = (pins == key_pattern(KEY_IDX));
  assign ft1  = {1'b0, filter_time};
  assign ft2  = {filter_time, 1'b0};

  always_comb begin
    cnt_nxt  = cnt_r;
    mode_nxt = mode_r;
    lc_nxt   = lc_r;
    ev       = '0;
    if (down) begin
      if (cnt_r < ft1) begin
        cnt_nxt = ft1;
      end else if (cnt_r < ft2) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end else begin
        if (mode_r == MODE_IDLE) begin
          mode_nxt = MODE_PRESSED;
          ev[0]    = '{v: 1'b1, code: key_code(KEY_IDX, OFS_PRESS)};
        end
        if ((long_time != '0) && (lc_r < long_time)) begin
          lc_nxt = lc_r + LT_W'(1);
          if ((lc_r + LT_W'(1)) == long_time) begin
            mode_nxt = MODE_LONG;
            ev[1]    = '{v: 1'b1, code: key_code(KEY_IDX, OFS_LONG)};
          end
        end
      end
    end else begin
      if (cnt_r > ft1) begin
        cnt_nxt = ft1;
      end else if (cnt_r != '0) begin
        cnt_nxt = cnt_r - CNT_W'(1);
      end else if ((mode_r == MODE_PRESSED) || (mode_r == MODE_LONG)) begin
        mode_nxt = MODE_IDLE;
        ev[0]    = '{v: 1'b1, code: key_code(KEY_IDX, OFS_RELEASE)};
      end
      lc_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= CNT_RESET;
      mode_r <= MODE_IDLE;
      lc_r   <= '0;
    end else if (scan) begin
      cnt_r  <= cnt_nxt;
      mode_r <= mode_nxt;
      lc_r   <= lc_nxt;
    end
  end

  assign mode = mode_r;

endmodule

[hdl/kdef_merge.sv]
`timescale 1ns / 1ps
// Merge stage: captures the event slots of all lanes and shifts them out
// one per cycle in key order. Depends on kdef_pkg.
module kdef_merge
  import kdef_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  kdef_evt_t [NSLOT-1:0] slots_in,
  output kdef_evt_t             wr,
  output logic                  last
);

  kdef_evt_t [NSLOT-1:0] slots_r;
  logic [SLOT_IW-1:0]    idx_r;
  logic                  busy_r;

  assign wr   = busy_r ? slots_r[0] : '0;
  assign last = busy_r && (idx_r == SLOT_IW'(NSLOT - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (load) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (busy_r) begin
      busy_r <= !last;
      idx_r  <= idx_r + SLOT_IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slots_r <= slots_in;
    end else if (busy_r) begin
      slots_r <= {kdef_evt_t'('0), slots_r[NSLOT-1:1]};
    end
  end

endmodule

[hdl/key_debounce_event_fifo_core.sv]
`timescale 1ns / 1ps
// Top level of the key debounce event FIFO: lanes, merge stage, code RAM.
// Depends on kdef_pkg, kdef_lane, kdef_merge and kdef_ram.
//
// Six key lanes debounce the four pin levels in parallel on a scan beat and
// each offers up to two event codes; the merge stage then walks all twelve
// slots in key order, one slot per cycle, and writes the valid ones into the code
// RAM through its single write port, so a scan beat keeps the block busy until
// the last slot is through. A pop beat passes through ST_POP for the registered
// RAM read and then ST_DONE; a pop of an empty FIFO, a clear or an unused action
// goes straight to ST_DONE. One result beat is produced per input beat and waits
// in an output register until taken. The FIFO has no full check: an overrun wraps
// the write pointer and may make the FIFO read as empty.
module key_debounce_event_fifo_core
  import kdef_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  kdef_in_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output kdef_out_t         out_data,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  localparam int unsigned PW = $clog2(FIFO_DEPTH);
  localparam logic [PW-1:0] PTR_LAST = PW'(FIFO_DEPTH - 1);

  kdef_state_t       state_r, state_nxt;
  logic [FT_W-1:0]   filter_time_r;
  logic [LT_W-1:0]   long_first_r, long_rest_r;
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CODE_W-1:0] res_code_r, res_code_nxt;
  logic              out_valid_r, out_valid_nxt;
  kdef_out_t         out_data_r, out_data_nxt;

  logic                  accept, scan, ram_re, empty;
  logic [3:0]            pins;
  kdef_evt_t [NSLOT-1:0] slots;
  kdef_evt_t             mwr;
  logic                  mlast;
  logic [2*NUM_KEYS-1:0] key_states;
  logic [CODE_W-1:0]     ram_rdata;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign scan = accept && (in_data.action == ACT_SCAN);
  assign pins = {in_data.key2_pressed, in_data.key1_pressed,
                 in_data.key0_pressed, in_data.wkup_pressed};
  assign empty = (rd_ptr_r == wr_ptr_r);

  for (genvar g = 0; g < NUM_KEYS; g++) begin : g_lane
    kdef_lane #(
      .KEY_IDX(g)
    ) u_lane (
      .clk        (clk),
      .rst_n      (rst_n),
      .scan       (scan),
      .pins       (pins),
      .filter_time(filter_time_r),
      .long_time  ((g == 0) ? long_first_r : long_rest_r),
      .mode       (key_states[2*g +: 2]),
      .ev         (slots[2*g +: 2])
    );
  end

  kdef_merge u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (scan),
    .slots_in(slots),
    .wr      (mwr),
    .last    (mlast)
  );

  kdef_ram #(
    .WIDTH(CODE_W),
    .DEPTH(FIFO_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (mwr.v),
    .waddr(wr_ptr_r),
    .wdata(mwr.code),
    .re   (ram_re),
    .raddr(rd_ptr_r),
    .rdata(ram_rdata)
  );

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    if (mwr.v) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PW'(1);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    rd_ptr_nxt    = rd_ptr_r;
    res_code_nxt  = res_code_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    ram_re        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_code_nxt = '0;
          state_nxt    = ST_DONE;
          case (in_data.action)
            ACT_SCAN: begin
              state_nxt = ST_SCAN;
            end
            ACT_POP: begin
              if (!empty) begin
                ram_re     = 1'b1;
                rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PW'(1);
                state_nxt  = ST_POP;
              end
            end
            ACT_CLEAR: begin
              rd_ptr_nxt = wr_ptr_r;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (mlast) begin
          state_nxt = ST_DONE;
        end
      end
      ST_POP: begin
        res_code_nxt = ram_rdata;
        state_nxt    = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{key_code: res_code_r, fifo_empty: empty,
                            key_states: key_states};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      wr_ptr_r      <= '0;
      rd_ptr_r      <= '0;
      out_valid_r   <= 1'b0;
      filter_time_r <= FT_W'(FT_RESET);
      long_first_r  <= LT_W'(LT_RESET);
      long_rest_r   <= LT_W'(LT_RESET);
    end else begin
      state_r     <= state_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          CFG_FILTER:     filter_time_r <= cfg_wdata[FT_W-1:0];
          CFG_LONG_FIRST: long_first_r  <= cfg_wdata[LT_W-1:0];
          CFG_LONG_REST:  long_rest_r   <= cfg_wdata[LT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    res_code_r <= res_code_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[hdl/kdef_chk.sv]
`timescale 1ns / 1ps
// Port-level checker for the key debounce event FIFO and its bind statement.
// Depends on kdef_pkg and key_debounce_event_fifo_core.
module kdef_chk
  import kdef_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input kdef_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted on two consecutive cycles");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.key_code <= CODE_MAX)
    else $error("key code out of range");

  a_mode_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.key_states[1:0] != 2'b10) &&
                  (out_data.key_states[3:2] != 2'b10) &&
                  (out_data.key_states[5:4] != 2'b10) &&
                  (out_data.key_states[7:6] != 2'b10) &&
                  (out_data.key_states[9:8] != 2'b10) &&
                  (out_data.key_states[11:10] != 2'b10))
    else $error("illegal key mode reported");

endmodule

bind key_debounce_event_fifo_core kdef_chk u_kdef_chk (.*);

[tb/sv/key_debounce_event_fifo_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the key debounce event FIFO: tracks register writes, keeps its own
// model of the key lanes and the code ring, and checks every result beat against it.
// Depends on kdef_pkg for the beat types, code offsets and register indexes.
module key_debounce_event_fifo_checker
  import kdef_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  kdef_in_t          in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  kdef_out_t         out_data,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata,
  output int                fail_count,
  output int                backlog
);

  // Pin pattern of key i sits in nibble i: wkup, key0, key1, key2, wkup+key0, key0+key1.
  localparam logic [4*NUM_KEYS-1:0] KEY_PINS = 24'h638421;

  logic [FT_W-1:0]   filter_ticks;
  logic [LT_W-1:0]   long_ticks_first;
  logic [LT_W-1:0]   long_ticks_rest;
  logic [CNT_W-1:0]  settle_count [NUM_KEYS];
  logic [1:0]        key_mode [NUM_KEYS];
  logic [LT_W-1:0]   held_ticks [NUM_KEYS];
  logic [CODE_W-1:0] code_ring [FIFO_DEPTH];
  int unsigned       wr_ptr;
  int unsigned       rd_ptr;
  kdef_out_t         awaited_reports [$];

  task automatic push_code(input int unsigned code);
    code_ring[wr_ptr] = CODE_W'(code);
    wr_ptr = (wr_ptr + 1) % FIFO_DEPTH;
  endtask

  task automatic scan_keys(input logic [3:0] pins);
    int unsigned ft;
    int unsigned lt;
    int unsigned cnt;
    ft = filter_ticks;
    for (int k = 0; k < NUM_KEYS; k++) begin
      lt = (k == 0) ? long_ticks_first : long_ticks_rest;
      cnt = settle_count[k];
      if (pins == KEY_PINS[4*k +: 4]) begin
        if (cnt < ft) begin
          settle_count[k] = CNT_W'(ft);
        end else if (cnt < 2 * ft) begin
          settle_count[k] = settle_count[k] + CNT_W'(1);
        end else begin
          if (key_mode[k] == MODE_IDLE) begin
            key_mode[k] = MODE_PRESSED;
            push_code(3 * k + OFS_PRESS);
          end
          if (lt != 0 && held_ticks[k] < lt) begin
            held_ticks[k] = held_ticks[k] + LT_W'(1);
            if (held_ticks[k] == lt) begin
              key_mode[k] = MODE_LONG;
              push_code(3 * k + OFS_LONG);
            end
          end
        end
      end else begin
        if (cnt > ft) begin
          settle_count[k] = CNT_W'(ft);
        end else if (cnt != 0) begin
          settle_count[k] = settle_count[k] - CNT_W'(1);
        end else if (key_mode[k] == MODE_PRESSED || key_mode[k] == MODE_LONG) begin
          key_mode[k] = MODE_IDLE;
          push_code(3 * k + OFS_RELEASE);
        end
        held_ticks[k] = '0;
      end
    end
  endtask

  task automatic run_key_beat(input kdef_in_t b, output kdef_out_t r);
    logic [3:0] pins;
    r = '0;
    pins = {b.key2_pressed, b.key1_pressed, b.key0_pressed, b.wkup_pressed};
    case (b.action)
      ACT_SCAN: begin
        scan_keys(pins);
      end
      ACT_POP: begin
        if (rd_ptr != wr_ptr) begin
          r.key_code = code_ring[rd_ptr];
          rd_ptr = (rd_ptr + 1) % FIFO_DEPTH;
        end
      end
      ACT_CLEAR: begin
        rd_ptr = wr_ptr;
      end
      default: begin
      end
    endcase
    r.fifo_empty = (rd_ptr == wr_ptr);
    for (int k = 0; k < NUM_KEYS; k++) begin
      r.key_states[2*k +: 2] = key_mode[k];
    end
  endtask

  always @(posedge clk) begin : track
    kdef_out_t want;
    if (!rst_n) begin
      filter_ticks = FT_W'(FT_RESET);
      long_ticks_first = LT_W'(LT_RESET);
      long_ticks_rest = LT_W'(LT_RESET);
      for (int k = 0; k < NUM_KEYS; k++) begin
        settle_count[k] = CNT_W'(FT_RESET / 2);
        key_mode[k] = MODE_IDLE;
        held_ticks[k] = '0;
      end
      wr_ptr = 0;
      rd_ptr = 0;
      awaited_reports.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_reports.size() == 0) begin
          $error("result beat with nothing expected: %p", out_data);
          fail_count++;
        end else begin
          want = awaited_reports.pop_front();
          if (out_data.key_code !== want.key_code) begin
            $error("key_code: expected %0d, got %0d", want.key_code, out_data.key_code);
            fail_count++;
          end
          if (out_data.fifo_empty !== want.fifo_empty) begin
            $error("fifo_empty: expected %0b, got %0b", want.fifo_empty, out_data.fifo_empty);
            fail_count++;
          end
          if (out_data.key_states !== want.key_states) begin
            $error("key_states: expected %03h, got %03h", want.key_states,
                   out_data.key_states);
            fail_count++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_addr)
          CFG_FILTER:     filter_ticks = cfg_wdata[FT_W-1:0];
          CFG_LONG_FIRST: long_ticks_first = cfg_wdata[LT_W-1:0];
          CFG_LONG_REST:  long_ticks_rest = cfg_wdata[LT_W-1:0];
          default: begin
          end
        endcase
      end
      if (in_valid && !in_stall) begin
        run_key_beat(in_data, want);
        awaited_reports.push_back(want);
      end
    end
    backlog <= awaited_reports.size();
  end

endmodule

[tb/sv/key_debounce_event_fifo_core_tb.sv]
`timescale 1ns / 1ps
// Testbench top for key_debounce_event_fifo_core: clock, reset, register setup and
// key press stimulus with random flow control; verdict from the checker's count.
// Depends on kdef_pkg, the block itself and key_debounce_event_fifo_checker.
module key_debounce_event_fifo_core_tb;
  import kdef_pkg::*;

  localparam int unsigned         DEPTH      = 16;
  localparam int                  IDLE_LIMIT = 5000;
  localparam int                  PHASES     = 10;
  localparam int                  PHASE_BEATS = 150;
  localparam logic [1:0]          ACT_NONE   = 2'd3;
  localparam logic [CFG_AW-1:0]   CFG_UNUSED = 2'd3;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  kdef_in_t          in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  kdef_out_t         out_data;
  logic              cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;
  int                fail_count;
  int                backlog;
  int                hold_req = 0;
  int                burst_left = 0;
  int                beats_sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  key_debounce_event_fifo_core #(.FIFO_DEPTH(DEPTH)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  key_debounce_event_fifo_checker #(.FIFO_DEPTH(DEPTH)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .backlog    (backlog)
  );

  function automatic kdef_in_t make_beat(input logic [1:0] act, input logic [3:0] pins);
    kdef_in_t b;
    b.action = act;
    b.wkup_pressed = pins[0];
    b.key0_pressed = pins[1];
    b.key1_pressed = pins[2];
    b.key2_pressed = pins[3];
    return b;
  endfunction

  task automatic send_beat(input kdef_in_t b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (in_stall);
    beats_sent++;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
  endtask

  task automatic program_regs(input int ft, input int lf, input int lr);
    drain();
    repeat (16) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= CFG_FILTER;
    cfg_wdata <= {12'($urandom), 4'(ft)};
    @(posedge clk);
    cfg_addr <= CFG_LONG_FIRST;
    cfg_wdata <= 16'(lf);
    @(posedge clk);
    cfg_addr <= CFG_LONG_REST;
    cfg_wdata <= 16'(lr);
    @(posedge clk);
    cfg_addr <= CFG_UNUSED;
    cfg_wdata <= 16'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic scan_run(input logic [3:0] pins, input int ticks, input int pop_pct,
                          input int noise_pct);
    for (int n = 0; n < ticks; n++) begin
      if ($urandom_range(0, 99) < pop_pct) send_beat(make_beat(ACT_POP, 4'($urandom)));
      if ($urandom_range(0, 99) < noise_pct) begin
        case ($urandom_range(0, 2))
          0: send_beat(make_beat(ACT_SCAN, 4'($urandom)));
          1: send_beat(make_beat(ACT_CLEAR, 4'($urandom)));
          default: send_beat(make_beat(ACT_NONE, 4'($urandom)));
        endcase
      end else begin
        send_beat(make_beat(ACT_SCAN, pins));
      end
    end
  endtask

  initial begin : rx_pattern
    int mode;
    int left;
    int hold_left;
    int hold_served;
    mode = 0;
    left = 0;
    hold_left = 0;
    hold_served = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_req != hold_served) begin
        hold_served = hold_req;
        hold_left = 400;
        out_stall <= 1'b1;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(20, 200);
        end
        left--;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 99) < 30);
          2: out_stall <= ($urandom_range(0, 99) < 70);
          default: out_stall <= ((left % 8) < 3);
        endcase
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    int ft;
    int lf;
    int lr;
    int lt_top;
    int pop_pct;
    int hold;
    int phase_end;
    logic [3:0] pins;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Power-on register values, empty FIFO and the unused action.
    send_beat(make_beat(ACT_POP, 4'b0000));
    send_beat(make_beat(ACT_CLEAR, 4'b0000));
    send_beat(make_beat(ACT_NONE, 4'b1111));
    send_beat(make_beat(ACT_SCAN, 4'b1111));
    send_beat(make_beat(ACT_POP, 4'b1111));

    // Zero filter time with the shortest long press on key 0 and none on the rest.
    program_regs(0, 1, 0);
    send_beat(make_beat(ACT_SCAN, 4'b0001));
    send_beat(make_beat(ACT_SCAN, 4'b0011));
    send_beat(make_beat(ACT_SCAN, 4'b0000));
    send_beat(make_beat(ACT_SCAN, 4'b0000));
    repeat (4) send_beat(make_beat(ACT_POP, 4'b0000));
    send_beat(make_beat(ACT_SCAN, 4'b1000));
    send_beat(make_beat(ACT_SCAN, 4'b0110));
    send_beat(make_beat(ACT_SCAN, 4'b0100));
    send_beat(make_beat(ACT_SCAN, 4'b0010));
    send_beat(make_beat(ACT_SCAN, 4'b0000));
    send_beat(make_beat(ACT_SCAN, 4'b0000));
    send_beat(make_beat(ACT_CLEAR, 4'b1010));
    send_beat(make_beat(ACT_POP, 4'b0101));
    send_beat(make_beat(ACT_SCAN, 4'b1111));
    send_beat(make_beat(ACT_POP, 4'b0000));

    // Long time lowered below the running count while key 1 stays held.
    program_regs(1, 30, 30);
    scan_run(4'b0010, 16, 20, 0);
    program_regs(1, 6, 6);
    scan_run(4'b0010, 20, 20, 0);
    scan_run(4'b0000, 6, 30, 0);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin ft = 1;  lf = 3;     lr = 5;     end
        1: begin ft = 15; lf = 65535; lr = 65535; end
        2: begin ft = 0;  lf = 0;     lr = 1;     end
        3: begin ft = 5;  lf = 100;   lr = 100;   end
        4: begin ft = 2;  lf = 0;     lr = 7;     end
        5: begin ft = 3;  lf = 9;     lr = 0;     end
        default: begin
          ft = $urandom_range(0, 4);
          lf = $urandom_range(0, 12);
          lr = $urandom_range(0, 12);
        end
      endcase
      program_regs(ft, lf, lr);
      lt_top = (lf > lr) ? lf : lr;
      if (lt_top > 120) lt_top = 8;
      pop_pct = (p == 0) ? 5 : $urandom_range(10, 60);
      if (p == 2) hold_req++;
      phase_end = beats_sent + PHASE_BEATS;
      while (beats_sent < phase_end) begin
        case ($urandom_range(0, 19))
          0, 1, 2: pins = 4'($urandom);
          3, 4, 5: pins = 4'b0000;
          default: pins = key_pattern($urandom_range(0, NUM_KEYS - 1));
        endcase
        if ($urandom_range(0, 9) < 3) hold = 2 * ft + 2 + lt_top + $urandom_range(0, 3);
        else hold = $urandom_range(0, 2 * ft + 3);
        scan_run(pins, hold, pop_pct, 4);
        if ($urandom_range(0, 9) < 7) scan_run(4'b0000, $urandom_range(0, 2 * ft + 3), pop_pct, 4);
        repeat ($urandom_range(0, 4)) send_beat(make_beat(ACT_POP, 4'($urandom)));
      end
    end

    drain();
    repeat (30) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
